FILE: design/asbd_pkg.sv
// ----------------------------------------------------------------------------
// asbd_pkg
// Shared constants, command codes and types for the audio stream buffer.
// ----------------------------------------------------------------------------
package asbd_pkg;

    localparam int BUF_BYTES   = 65536;
    localparam int BUF_AW      = $clog2(BUF_BYTES);
    localparam int FILL_W      = BUF_AW + 1;
    localparam int MAX_PULL    = 64;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register byte offsets.
    localparam logic [15:0] OFS_RATE     = 16'd0;
    localparam logic [15:0] OFS_CHANNELS = 16'd4;
    localparam logic [15:0] OFS_SAMPLES  = 16'd8;
    localparam logic [15:0] OFS_SIZE     = 16'd12;
    localparam logic [15:0] OFS_INIT     = 16'd16;
    localparam logic [15:0] OFS_COUNT    = 16'd20;

    // Access kinds on the input channel.
    localparam logic [1:0] FUNC_REG_WR = 2'd0;
    localparam logic [1:0] FUNC_REG_RD = 2'd1;
    localparam logic [1:0] FUNC_BUF_WR = 2'd2;
    localparam logic [1:0] FUNC_PULL   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_BAD_INIT = 2'd2;

    typedef enum logic [3:0] {
        OP_ACK,
        OP_WR_RATE,
        OP_WR_CHAN,
        OP_WR_SAMP,
        OP_WR_INIT,
        OP_WR_COUNT,
        OP_RD_RATE,
        OP_RD_CHAN,
        OP_RD_SAMP,
        OP_RD_SIZE,
        OP_RD_INIT,
        OP_RD_COUNT,
        OP_BUF_WR,
        OP_PULL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BUF_AW-1:0] baddr;
        logic [31:0]       data;
        logic [LEN_W-1:0]  n;
    } cmd_t;

endpackage

FILE: design/asbd_ram.sv
// ----------------------------------------------------------------------------
// asbd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module asbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/asbd_front.sv
// ----------------------------------------------------------------------------
// asbd_front
// Accepts input words, decodes them into commands and pushes them to the queue.
// ----------------------------------------------------------------------------
module asbd_front
    import asbd_pkg::*;
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [15:0]       addr,
    input  logic [31:0]       wdata,
    input  logic [LEN_W-1:0]  length,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic full_word;

    assign in_ready  = !q_full;
    assign full_word = (length == LEN_W'(4));

    always_comb
    begin
        push_cmd.op    = OP_ACK;
        push_cmd.baddr = BUF_AW'(addr);
        push_cmd.data  = wdata;
        push_cmd.n     = (length > LEN_W'(MAX_PULL)) ? LEN_W'(MAX_PULL) : length;

        unique case (func)
            FUNC_REG_WR:
            begin
                // Anything but a full-word write leaves the registers alone.
                if (full_word)
                begin
                    unique case (addr)
                        OFS_RATE:     push_cmd.op = OP_WR_RATE;
                        OFS_CHANNELS: push_cmd.op = OP_WR_CHAN;
                        OFS_SAMPLES:  push_cmd.op = OP_WR_SAMP;
                        OFS_INIT:     push_cmd.op = OP_WR_INIT;
                        OFS_COUNT:    push_cmd.op = OP_WR_COUNT;
                        default:      push_cmd.op = OP_ACK;
                    endcase
                end
            end
            FUNC_REG_RD:
            begin
                unique case (addr)
                    OFS_RATE:     push_cmd.op = OP_RD_RATE;
                    OFS_CHANNELS: push_cmd.op = OP_RD_CHAN;
                    OFS_SAMPLES:  push_cmd.op = OP_RD_SAMP;
                    OFS_SIZE:     push_cmd.op = OP_RD_SIZE;
                    OFS_INIT:     push_cmd.op = OP_RD_INIT;
                    OFS_COUNT:    push_cmd.op = OP_RD_COUNT;
                    default:      push_cmd.op = OP_ACK;
                endcase
            end
            FUNC_BUF_WR: push_cmd.op = OP_BUF_WR;
            FUNC_PULL:   push_cmd.op = OP_PULL;
            default:     push_cmd.op = OP_ACK;
        endcase
    end

    // A pull of zero bytes yields no result and changes nothing, so it is dropped here.
    assign push = in_valid && !q_full && !(func == FUNC_PULL && length == '0);

endmodule

FILE: design/asbd_queue.sv
// ----------------------------------------------------------------------------
// asbd_queue
// Short command FIFO that decouples the decoder from the execution unit.
// ----------------------------------------------------------------------------
module asbd_queue
    import asbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic cmd_valid,
    output cmd_t cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= QUEUE_AW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QUEUE_AW'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/asbd_back.sv
// ----------------------------------------------------------------------------
// asbd_back
// Execution unit: device registers, ring buffer pointers and playback sequencer.
// ----------------------------------------------------------------------------
module asbd_back
    import asbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       rdata,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic [1:0]        status
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t             state_reg,     state_next;
    logic [31:0]        rate_reg,      rate_next;
    logic [31:0]        chan_reg,      chan_next;
    logic [31:0]        samp_reg,      samp_next;
    logic [31:0]        init_reg,      init_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic [BUF_AW-1:0]  rp_reg,        rp_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic [LEN_W-1:0]   n_reg,         n_next;
    logic [LEN_W-1:0]   nread_reg,     nread_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        rdata_reg,     rdata_next;
    logic [7:0]         byte_reg,      byte_next;
    logic               last_reg,      last_next;
    logic [1:0]         status_reg,    status_next;

    logic               out_free;
    logic               load;
    logic               ram_we;
    logic [BUF_AW-1:0]  ram_raddr;
    logic [7:0]         ram_q;
    logic [IDX_W-1:0]   idx_sel;
    logic [32:0]        free_space;
    logic               final_byte;

    assign out_free   = !out_valid_reg || out_ready;
    assign free_space = 33'(BUF_BYTES) - 33'(fill_reg);
    assign final_byte = ((LEN_W'(idx_reg) + 1'b1) == n_reg);
    assign load       = (state_reg == ST_EMIT) && out_free;

    // The read address runs one byte ahead whenever a byte leaves, so the
    // registered read always holds the byte for the current index.
    assign idx_sel   = load ? IDX_W'(idx_reg + 1'b1) : idx_reg;
    assign ram_raddr = BUF_AW'(rp_reg + BUF_AW'(idx_sel));
    assign ram_we    = (state_reg == ST_IDLE) && cmd_valid && out_free
                       && (cmd.op == OP_BUF_WR);

    asbd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.baddr),
        .wdata (cmd.data[7:0]),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        chan_next      = chan_reg;
        samp_next      = samp_reg;
        init_next      = init_reg;
        fill_next      = fill_reg;
        rp_next        = rp_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        nread_next     = nread_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rdata_next     = rdata_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_PULL)
                begin
                    pop        = 1'b1;
                    n_next     = cmd.n;
                    nread_next = (fill_reg < FILL_W'(cmd.n)) ? LEN_W'(fill_reg) : cmd.n;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (cmd_valid && out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    rdata_next     = '0;
                    byte_next      = '0;
                    last_next      = 1'b1;
                    status_next    = STAT_OK;
                    unique case (cmd.op)
                        OP_WR_RATE: rate_next = cmd.data;
                        OP_WR_CHAN: chan_next = cmd.data;
                        OP_WR_SAMP: samp_next = cmd.data;
                        OP_WR_INIT:
                        begin
                            init_next = cmd.data;
                            if (cmd.data != '0)
                            begin
                                if (rate_reg == '0 || chan_reg == '0 || samp_reg == '0)
                                begin
                                    status_next = STAT_BAD_INIT;
                                end
                                else
                                begin
                                    rp_next   = '0;
                                    fill_next = '0;
                                end
                            end
                        end
                        OP_WR_COUNT:
                        begin
                            if ({1'b0, cmd.data} > free_space)
                            begin
                                status_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                fill_next = FILL_W'(fill_reg + cmd.data[FILL_W-1:0]);
                            end
                        end
                        OP_RD_RATE:  rdata_next = rate_reg;
                        OP_RD_CHAN:  rdata_next = chan_reg;
                        OP_RD_SAMP:  rdata_next = samp_reg;
                        OP_RD_SIZE:  rdata_next = 32'(BUF_BYTES);
                        OP_RD_INIT:  rdata_next = init_reg;
                        OP_RD_COUNT: rdata_next = 32'(fill_reg);
                        OP_ACK, OP_BUF_WR, OP_PULL:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rdata_next     = '0;
                    byte_next      = (LEN_W'(idx_reg) < nread_reg) ? ram_q : 8'd0;
                    last_next      = final_byte;
                    status_next    = STAT_OK;
                    idx_next       = IDX_W'(idx_reg + 1'b1);
                    if (final_byte)
                    begin
                        rp_next    = BUF_AW'(rp_reg + BUF_AW'(nread_reg));
                        fill_next  = FILL_W'(fill_reg - FILL_W'(nread_reg));
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= '0;
            chan_reg      <= '0;
            samp_reg      <= '0;
            init_reg      <= '0;
            fill_reg      <= '0;
            rp_reg        <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            nread_reg     <= '0;
            out_valid_reg <= 1'b0;
            rdata_reg     <= '0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            chan_reg      <= chan_next;
            samp_reg      <= samp_next;
            init_reg      <= init_next;
            fill_reg      <= fill_next;
            rp_reg        <= rp_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            nread_reg     <= nread_next;
            out_valid_reg <= out_valid_next;
            rdata_reg     <= rdata_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;
    assign status    = status_reg;

endmodule

FILE: design/audio_stream_buffer_device_unit.sv
// Register and buffer accesses give a single result each, via the command queue and the
// output register. A pull of n bytes (capped at MAX_PULL) holds the execution unit and
// gives one byte per cycle unless out_ready stalls it (one buffer read per cycle).
// A two-entry command queue lets new words be accepted while a pull is playing out.
// Asynchronous reset clears the registers, read pointer, fill count and queue; the
// sample buffer is not cleared.
// ----------------------------------------------------------------------------
// audio_stream_buffer_device_unit
// Register-mapped audio output device with a byte ring buffer and playback pulls.
// ----------------------------------------------------------------------------
module audio_stream_buffer_device_unit
    import asbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [15:0]       addr,
    input  logic [31:0]       wdata,
    input  logic [LEN_W-1:0]  length,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       rdata,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic [1:0]        status
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic cmd_valid;
    cmd_t cmd;

    asbd_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .addr     (addr),
        .wdata    (wdata),
        .length   (length),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    asbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    asbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rdata     (rdata),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status)
    );

endmodule

FILE: test/audio_stream_buffer_device_unit_tb.sv
// ----------------------------------------------------------------------------
// audio_stream_buffer_device_unit_tb
// Self-checking bench for the audio stream buffer: a short table of register,
// buffer and playback words, then random traffic built mostly from feed-and-
// play sequences. Every result is checked against a local model of the device.
// ----------------------------------------------------------------------------
module audio_stream_buffer_device_unit_tb;
    import asbd_pkg::*;

    localparam int WORD_TARGET = 410;
    localparam int QUIET_WORDS = 60;
    localparam int TAIL_CYCLES = 80;
    localparam int DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] rdata;
        logic [7:0]  out_byte;
        logic        last;
        logic [1:0]  status;
    } play_result_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      offs;
        logic [31:0]      value;
        logic [LEN_W-1:0] len;
        logic             known;
        logic [31:0]      known_rdata;
        logic [1:0]       known_status;
    } access_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       func;
    logic [15:0]      addr;
    logic [31:0]      wdata;
    logic [LEN_W-1:0] length;
    logic             out_valid;
    logic             out_ready;
    logic [31:0]      rdata;
    logic [7:0]       out_byte;
    logic             last;
    logic [1:0]       status;

    // Device state as the bench believes it to be.
    logic [31:0]       dev_rate;
    logic [31:0]       dev_chans;
    logic [31:0]       dev_samples;
    logic [31:0]       dev_init;
    logic [FILL_W-1:0] dev_fill;
    logic [BUF_AW-1:0] dev_rptr;
    logic [7:0]        shadow_buf [0:BUF_BYTES-1];
    bit                byte_known [0:BUF_BYTES-1];

    play_result_t expected_results [$];
    play_result_t next_want;
    access_row_t  opening_rows [0:25];

    int  mismatches;
    int  words_sent;
    int  sent_by_func [0:3];
    int  results_checked;
    int  overflow_seen;
    int  bad_init_seen;
    int  gap_odds;
    int  stall_odds;
    bit  quiet_tail;

    audio_stream_buffer_device_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .addr      (addr),
        .wdata     (wdata),
        .length    (length),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rdata     (rdata),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("Run timed out with %0d results outstanding.", expected_results.size());
        $display("audio_stream_buffer_device_unit_tb: FAIL");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        begin
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
        end
    endtask

    // Works out the results of one accepted word and updates the local state.
    task automatic predict_access(input logic [1:0] f, input logic [15:0] a,
                                  input logic [31:0] d, input logic [LEN_W-1:0] n);
        logic [31:0]       rd;
        logic [1:0]        st;
        logic [BUF_AW-1:0] pos;
        int                take;
        int                avail;
        begin
            rd = '0;
            st = STAT_OK;
            case (f)
                FUNC_REG_WR:
                begin
                    if (n == LEN_W'(4))
                    begin
                        case (a)
                            OFS_RATE:     dev_rate = d;
                            OFS_CHANNELS: dev_chans = d;
                            OFS_SAMPLES:  dev_samples = d;
                            OFS_INIT:
                            begin
                                dev_init = d;
                                if (d != 0)
                                begin
                                    if (dev_rate == 0 || dev_chans == 0 || dev_samples == 0)
                                        st = STAT_BAD_INIT;
                                    else
                                    begin
                                        dev_rptr = '0;
                                        dev_fill = '0;
                                    end
                                end
                            end
                            OFS_COUNT:
                            begin
                                if (longint'(d) > longint'(BUF_BYTES) - longint'(dev_fill))
                                    st = STAT_OVERFLOW;
                                else
                                    dev_fill = dev_fill + FILL_W'(d);
                            end
                            default: ;
                        endcase
                    end
                    if (st == STAT_OVERFLOW)
                        overflow_seen++;
                    if (st == STAT_BAD_INIT)
                        bad_init_seen++;
                    expected_results.push_back('{32'h0, 8'h00, 1'b1, st});
                end
                FUNC_REG_RD:
                begin
                    case (a)
                        OFS_RATE:     rd = dev_rate;
                        OFS_CHANNELS: rd = dev_chans;
                        OFS_SAMPLES:  rd = dev_samples;
                        OFS_SIZE:     rd = 32'(BUF_BYTES);
                        OFS_INIT:     rd = dev_init;
                        OFS_COUNT:    rd = 32'(dev_fill);
                        default:      rd = '0;
                    endcase
                    expected_results.push_back('{rd, 8'h00, 1'b1, STAT_OK});
                end
                FUNC_BUF_WR:
                begin
                    shadow_buf[a[BUF_AW-1:0]] = d[7:0];
                    byte_known[a[BUF_AW-1:0]] = 1'b1;
                    expected_results.push_back('{32'h0, 8'h00, 1'b1, STAT_OK});
                end
                default:
                begin
                    take = (n > MAX_PULL) ? MAX_PULL : int'(n);
                    avail = (take < dev_fill) ? take : int'(dev_fill);
                    for (int i = 0; i < take; i++)
                    begin
                        pos = dev_rptr + BUF_AW'(i);
                        expected_results.push_back('{32'h0,
                            (i < avail) ? shadow_buf[pos] : 8'h00,
                            (i == take - 1), STAT_OK});
                    end
                    dev_rptr = dev_rptr + BUF_AW'(avail);
                    dev_fill = dev_fill - FILL_W'(avail);
                end
            endcase
        end
    endtask

    // Offers one word, waits for it to be taken, then records what it should give.
    task automatic send_access(input logic [1:0] f, input logic [15:0] a,
                               input logic [31:0] d, input logic [LEN_W-1:0] n,
                               input bit fixed, input logic [31:0] fixed_rdata,
                               input logic [1:0] fixed_status);
        begin
            if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            in_valid <= 1'b1;
            func     <= f;
            addr     <= a;
            wdata    <= d;
            length   <= n;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_access(f, a, d, n);
            if (fixed)
            begin
                void'(expected_results.pop_back());
                expected_results.push_back('{fixed_rdata, 8'h00, 1'b1, fixed_status});
            end
            words_sent++;
            sent_by_func[f]++;
        end
    endtask

    // A pull may only play bytes that have been written, so any missing ones
    // in the span it will take are filled in first.
    task automatic pull_bytes(input logic [LEN_W-1:0] n);
        int                take;
        int                avail;
        logic [BUF_AW-1:0] pos;
        begin
            take = (n > MAX_PULL) ? MAX_PULL : int'(n);
            avail = (take < dev_fill) ? take : int'(dev_fill);
            for (int i = 0; i < avail; i++)
            begin
                pos = dev_rptr + BUF_AW'(i);
                if (!byte_known[pos])
                    send_access(FUNC_BUF_WR, pos, $urandom, LEN_W'($urandom), 0, '0, STAT_OK);
            end
            send_access(FUNC_PULL, 16'($urandom), $urandom, n, 0, '0, STAT_OK);
        end
    endtask

    function automatic logic [LEN_W-1:0] random_pull_len();
        int pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                return '0;
            else if (pick < 5)
                return LEN_W'($urandom_range(MAX_PULL + 1, 127));
            else
                return LEN_W'($urandom_range(1, MAX_PULL));
        end
    endfunction

    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (expected_results.size() != 0);
        end
    endtask

    // Writes a run of bytes just past the buffered data, announces them through
    // the count register and then issues one to three pulls from the read pointer.
    task automatic feed_and_play();
        int                burst;
        logic [BUF_AW-1:0] wp;
        begin
            burst = ($urandom_range(0, 7) == 0) ? MAX_PULL : $urandom_range(1, 12);
            wp = dev_rptr + dev_fill[BUF_AW-1:0];
            for (int j = 0; j < burst; j++)
                send_access(FUNC_BUF_WR, wp + BUF_AW'(j), $urandom, LEN_W'($urandom),
                            0, '0, STAT_OK);
            send_access(FUNC_REG_WR, OFS_COUNT, 32'(burst), LEN_W'(4), 0, '0, STAT_OK);
            if ($urandom_range(0, 3) == 0)
                send_access(FUNC_REG_RD, OFS_COUNT, $urandom, LEN_W'($urandom), 0, '0, STAT_OK);
            repeat ($urandom_range(1, 3))
                pull_bytes(random_pull_len());
        end
    endtask

    task automatic random_word();
        int               pick;
        logic [15:0]      a;
        logic [31:0]      d;
        logic [LEN_W-1:0] n;
        begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 4) != 0) ? LEN_W'(4) : LEN_W'($urandom);
            if (pick < 35)
                feed_and_play();
            else if (pick < 50)
            begin
                a = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 5) * 4) : 16'($urandom);
                send_access(FUNC_REG_RD, a, $urandom, LEN_W'($urandom), 0, '0, STAT_OK);
            end
            else if (pick < 65)
            begin
                case ($urandom_range(0, 3))
                    0:       a = OFS_RATE;
                    1:       a = OFS_CHANNELS;
                    2:       a = OFS_SAMPLES;
                    default: a = 16'($urandom);
                endcase
                d = ($urandom_range(0, 6) == 0) ? 32'h0 : $urandom;
                send_access(FUNC_REG_WR, a, d, n, 0, '0, STAT_OK);
            end
            else if (pick < 70)
            begin
                d = ($urandom_range(0, 9) < 3) ? 32'h0 : $urandom;
                send_access(FUNC_REG_WR, OFS_INIT, d, n, 0, '0, STAT_OK);
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 4))
                    0:       d = $urandom;
                    1:       d = 32'(BUF_BYTES) - 32'(dev_fill) + 32'($urandom_range(0, 1));
                    default: d = $urandom_range(0, 200);
                endcase
                send_access(FUNC_REG_WR, OFS_COUNT, d, n, 0, '0, STAT_OK);
            end
            else if (pick < 85)
                send_access(FUNC_BUF_WR, 16'($urandom), $urandom, LEN_W'($urandom),
                            0, '0, STAT_OK);
            else if (pick < 98)
                pull_bytes(random_pull_len());
            else
                drain_results();
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                note_mismatch("result with nothing expected", {24'h0, out_byte}, 32'h0);
            else
            begin
                next_want = expected_results.pop_front();
                results_checked++;
                if (rdata !== next_want.rdata)
                    note_mismatch("rdata", rdata, next_want.rdata);
                if (out_byte !== next_want.out_byte)
                    note_mismatch("out_byte", {24'h0, out_byte}, {24'h0, next_want.out_byte});
                if (last !== next_want.last)
                    note_mismatch("last", {31'h0, last}, {31'h0, next_want.last});
                if (status !== next_want.status)
                    note_mismatch("status", {30'h0, status}, {30'h0, next_want.status});
            end
        end
    end

    initial
    begin
        int next_shuffle;
        int waited;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_REG_RD;
        addr     <= '0;
        wdata    <= '0;
        length   <= '0;
        dev_rate    = '0;
        dev_chans   = '0;
        dev_samples = '0;
        dev_init    = '0;
        dev_fill    = '0;
        dev_rptr    = '0;
        mismatches = 0;
        words_sent = 0;
        results_checked = 0;
        overflow_seen = 0;
        bad_init_seen = 0;
        for (int k = 0; k < 4; k++)
            sent_by_func[k] = 0;
        gap_odds = 3;
        stall_odds = 3;
        quiet_tail = 1'b0;

        // Words whose answer is obvious carry it in the table; pulls are predicted.
        opening_rows = '{
            '{FUNC_REG_RD, OFS_RATE,     32'h0,                 7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_RD, OFS_SIZE,     32'h0,                 7'd0,   1'b1, 32'(BUF_BYTES),    STAT_OK},
            '{FUNC_REG_RD, 16'hFFFF,     32'hFFFF_FFFF,         7'd127, 1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_INIT,     32'h1,                 7'd4,   1'b1, 32'h0,             STAT_BAD_INIT},
            '{FUNC_REG_RD, OFS_INIT,     32'h0,                 7'd4,   1'b1, 32'h1,             STAT_OK},
            '{FUNC_REG_WR, OFS_RATE,     32'hFFFF_FFFF,         7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_CHANNELS, 32'h2,                 7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_SAMPLES,  32'd1024,              7'd2,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_INIT,     32'hFFFF_FFFF,         7'd4,   1'b1, 32'h0,             STAT_BAD_INIT},
            '{FUNC_REG_WR, OFS_SAMPLES,  32'd1024,              7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_RD, OFS_SAMPLES,  32'h0,                 7'd1,   1'b1, 32'd1024,          STAT_OK},
            '{FUNC_REG_WR, OFS_SIZE,     32'h5,                 7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_RD, OFS_SIZE,     32'h0,                 7'd4,   1'b1, 32'(BUF_BYTES),    STAT_OK},
            '{FUNC_REG_WR, OFS_COUNT,    32'(BUF_BYTES),        7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_RD, OFS_COUNT,    32'h0,                 7'd4,   1'b1, 32'(BUF_BYTES),    STAT_OK},
            '{FUNC_REG_WR, OFS_COUNT,    32'h1,                 7'd4,   1'b1, 32'h0,             STAT_OVERFLOW},
            '{FUNC_REG_WR, OFS_INIT,     32'hFFFF_FFFF,         7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_COUNT,    32'(BUF_BYTES + 1),    7'd4,   1'b1, 32'h0,             STAT_OVERFLOW},
            '{FUNC_BUF_WR, 16'h0000,     32'hFFFF_FFFF,         7'd0,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_BUF_WR, 16'hFFFF,     32'h0000_005A,         7'd127, 1'b1, 32'h0,             STAT_OK},
            '{FUNC_BUF_WR, 16'h0001,     32'h0000_00A5,         7'd1,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, OFS_COUNT,    32'h2,                 7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_PULL,   16'h0000,     32'h0,                 7'd0,   1'b0, 32'h0,             STAT_OK},
            '{FUNC_PULL,   16'h0000,     32'h0,                 7'd127, 1'b0, 32'h0,             STAT_OK},
            '{FUNC_REG_RD, OFS_COUNT,    32'h0,                 7'd4,   1'b1, 32'h0,             STAT_OK},
            '{FUNC_REG_WR, 16'h0003,     32'hFFFF_FFFF,         7'd4,   1'b1, 32'h0,             STAT_OK}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 26; r++)
        begin
            if (opening_rows[r].kind == FUNC_PULL)
                pull_bytes(opening_rows[r].len);
            else
                send_access(opening_rows[r].kind, opening_rows[r].offs, opening_rows[r].value,
                            opening_rows[r].len, opening_rows[r].known,
                            opening_rows[r].known_rdata, opening_rows[r].known_status);
        end

        // Hold the sender off once so the device runs completely dry.
        drain_results();

        next_shuffle = words_sent;
        while (words_sent < WORD_TARGET)
        begin
            if (words_sent >= next_shuffle)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 2;
                    default: stall_odds = 8;
                endcase
                next_shuffle = words_sent + 40;
            end
            if (words_sent >= WORD_TARGET - QUIET_WORDS)
                quiet_tail = 1'b1;
            random_word();
        end

        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", 32'h0, expected_results.size());

        $display("Sent %0d words: %0d register writes, %0d reads, %0d buffer writes, %0d pulls.",
                 words_sent, sent_by_func[FUNC_REG_WR], sent_by_func[FUNC_REG_RD],
                 sent_by_func[FUNC_BUF_WR], sent_by_func[FUNC_PULL]);
        $display("Checked %0d results, including %0d overflow and %0d bad init rejections.",
                 results_checked, overflow_seen, bad_init_seen);
        if (mismatches == 0)
            $display("audio_stream_buffer_device_unit_tb: PASS");
        else
            $display("audio_stream_buffer_device_unit_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/asbd_pkg.sv
design/asbd_ram.sv
design/asbd_front.sv
design/asbd_queue.sv
design/asbd_back.sv
design/audio_stream_buffer_device_unit.sv
test/audio_stream_buffer_device_unit_tb.sv
